[hw/rtl/rrhop_pkg.sv]
// shared codes and types for the request/reply retry hop controller
`default_nettype none

package rrhop_pkg;

    // event codes carried on cmd
    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_START_READ  = 3'd1,
        CMD_START_WRITE = 3'd2,
        CMD_TX_DONE     = 3'd3,
        CMD_PKT_RX      = 3'd4,
        CMD_EXT_HOP     = 3'd5,
        CMD_RSVD6       = 3'd6,
        CMD_RSVD7       = 3'd7
    } cmd_t;

    // transaction outcome reported on status
    typedef enum logic [1:0] {
        STATUS_NONE    = 2'd0,
        STATUS_SUCCESS = 2'd1,
        STATUS_FAIL    = 2'd2,
        STATUS_RSVD    = 2'd3
    } status_t;

    // configuration register indexes
    localparam logic [1:0] CFG_HOP_COUNT      = 2'd0;
    localparam logic [1:0] CFG_LISTEN_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MAX_RETRIES    = 2'd2;

    // configuration reset values
    localparam logic [4:0] HOP_COUNT_RESET      = 5'd4;
    localparam logic [7:0] LISTEN_TIMEOUT_RESET = 8'd40;
    localparam logic [7:0] MAX_RETRIES_RESET    = 8'd20;

    // packet types
    localparam logic [4:0] TYPE_READ_REQ   = 5'd2;
    localparam logic [4:0] TYPE_SET_REQ    = 5'd3;
    localparam logic [4:0] TYPE_READ_REPLY = 5'd2;
    localparam logic [4:0] TYPE_SET_ACK    = 5'd4;
    localparam logic [4:0] TYPE_NONE       = 5'd0;

    // hop sequence limit; the 4-bit position caps it at 16
    localparam int          MAX_HOP_CHANNELS = 16;
    localparam int          HOP_CAP_INT      = (MAX_HOP_CHANNELS < 16) ? MAX_HOP_CHANNELS : 16;
    localparam logic [4:0]  HOP_CAP          = 5'(HOP_CAP_INT);

endpackage

`default_nettype wire

[hw/rtl/request_reply_retry_hop_controller.sv]
// top level of the request/reply retry hop controller
`default_nettype none

// Takes one event per request on the input channel (tick, start read, start
// write, tx done, packet received, external hop) and returns exactly one result
// per request. One request is taken per clock while the input channel is not
// stalled; each passes through the input register and then the result register,
// with the controller state (phase, kind, listen timer, retry count, hop index)
// updated as it moves from the input register into the result register. The input
// channel is stalled only while the input register holds a request and the
// result register holds an untaken result that the output side stalls.
// Configuration (hop count, listen timeout, max retries) is written through
// cfg_we/cfg_index/cfg_data; writes to index 3 are ignored. A hop count of 0
// keeps the hop position at 0, and counts above 16 wrap at 16.
module request_reply_retry_hop_controller (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [7:0]            cfg_data,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [2:0]            cmd,
    input  wire logic                  rx_valid,
    input  wire logic [4:0]            rx_type,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       tx_request,
    output logic [4:0]                 tx_packet_type,
    output logic                       hop_now,
    output logic [3:0]                 hop_position,
    output rrhop_pkg::status_t         status,
    output logic                       done_kind,
    output logic                       busy_res
);

    import rrhop_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TX     = 2'd1,
        PH_LISTEN = 2'd2,
        PH_RSVD   = 2'd3
    } phase_t;

    // configuration registers
    logic [4:0] hop_count_reg;
    logic [7:0] listen_timeout_reg;
    logic [7:0] max_retries_reg;

    // input register
    logic       in_valid_reg;
    cmd_t       cmd_reg;
    logic       rx_valid_reg;
    logic [4:0] rx_type_reg;

    // controller state
    phase_t     phase_reg,        phase_next;
    logic       kind_reg,         kind_next;
    logic [7:0] listen_timer_reg, listen_timer_next;
    logic [7:0] retry_count_reg,  retry_count_next;
    logic [3:0] hop_index_reg,    hop_index_next;

    // result register
    logic       out_valid_reg;
    logic       tx_request_reg,   tx_request_next;
    logic [4:0] tx_type_reg,      tx_type_next;
    logic       hop_now_reg,      hop_now_next;
    status_t    status_reg,       status_next;
    logic       done_kind_reg,    done_kind_next;

    logic       advance;
    logic [4:0] hop_limit;
    logic [3:0] hop_step;
    logic [4:0] hop_inc;
    logic [8:0] timer_inc;
    logic [8:0] retry_inc;
    logic [4:0] want_type;

    // request moves into the result register when that slot is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    // wrap point: hop count limited to the sequence cap
    assign hop_limit = (hop_count_reg > HOP_CAP) ? HOP_CAP : hop_count_reg;
    assign hop_inc   = {1'b0, hop_index_reg} + 5'd1;
    assign hop_step  = (hop_inc >= hop_limit) ? 4'd0 : hop_inc[3:0];

    assign timer_inc = {1'b0, listen_timer_reg} + 9'd1;
    assign retry_inc = {1'b0, retry_count_reg} + 9'd1;
    assign want_type = kind_reg ? TYPE_SET_ACK : TYPE_READ_REPLY;

    // event decode against the current state
    always_comb
    begin
        phase_next        = phase_reg;
        kind_next         = kind_reg;
        listen_timer_next = listen_timer_reg;
        retry_count_next  = retry_count_reg;
        hop_index_next    = hop_index_reg;
        tx_request_next   = 1'b0;
        hop_now_next      = 1'b0;
        status_next       = STATUS_NONE;
        done_kind_next    = 1'b0;

        unique case (cmd_reg)
            CMD_TICK:
            begin
                if (phase_reg == PH_LISTEN)
                begin
                    if (timer_inc > {1'b0, listen_timeout_reg})
                    begin
                        // listen timed out: retry or give up
                        listen_timer_next = 8'd0;
                        if (retry_inc > {1'b0, max_retries_reg})
                        begin
                            retry_count_next = 8'd0;
                            status_next      = STATUS_FAIL;
                            done_kind_next   = kind_reg;
                            phase_next       = PH_IDLE;
                            hop_index_next   = hop_step;
                            hop_now_next     = 1'b1;
                        end
                        else
                        begin
                            retry_count_next = retry_inc[7:0];
                            phase_next       = PH_TX;
                            tx_request_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        listen_timer_next = timer_inc[7:0];
                    end
                end
            end
            CMD_START_READ, CMD_START_WRITE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    kind_next         = (cmd_reg == CMD_START_WRITE);
                    phase_next        = PH_TX;
                    retry_count_next  = 8'd0;
                    listen_timer_next = 8'd0;
                    tx_request_next   = 1'b1;
                end
            end
            CMD_TX_DONE:
            begin
                if (phase_reg == PH_TX)
                begin
                    hop_index_next    = hop_step;
                    hop_now_next      = 1'b1;
                    phase_next        = PH_LISTEN;
                    listen_timer_next = 8'd0;
                end
            end
            CMD_PKT_RX:
            begin
                if (phase_reg == PH_LISTEN)
                begin
                    // any packet while listening hops
                    hop_index_next = hop_step;
                    hop_now_next   = 1'b1;
                    if (rx_valid_reg && (rx_type_reg == want_type))
                    begin
                        status_next       = STATUS_SUCCESS;
                        done_kind_next    = kind_reg;
                        phase_next        = PH_IDLE;
                        retry_count_next  = 8'd0;
                        listen_timer_next = 8'd0;
                    end
                end
            end
            CMD_EXT_HOP:
            begin
                hop_index_next = hop_step;
                hop_now_next   = 1'b1;
            end
            default:
            begin
                // unused codes are ignored
            end
        endcase

        tx_type_next = tx_request_next ? (kind_next ? TYPE_SET_REQ : TYPE_READ_REQ) : TYPE_NONE;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_count_reg      <= HOP_COUNT_RESET;
            listen_timeout_reg <= LISTEN_TIMEOUT_RESET;
            max_retries_reg    <= MAX_RETRIES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HOP_COUNT:      hop_count_reg      <= cfg_data[4:0];
                CFG_LISTEN_TIMEOUT: listen_timeout_reg <= cfg_data;
                CFG_MAX_RETRIES:    max_retries_reg    <= cfg_data;
                default:
                begin
                    // no register at this index
                end
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg      <= cmd_t'(cmd);
            rx_valid_reg <= rx_valid;
            rx_type_reg  <= rx_type;
        end
    end

    // controller state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            kind_reg         <= 1'b0;
            listen_timer_reg <= 8'd0;
            retry_count_reg  <= 8'd0;
            hop_index_reg    <= 4'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg        <= phase_next;
                kind_reg         <= kind_next;
                listen_timer_reg <= listen_timer_next;
                retry_count_reg  <= retry_count_next;
                hop_index_reg    <= hop_index_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload; hop position and busy follow the state registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tx_request_reg <= tx_request_next;
            tx_type_reg    <= tx_type_next;
            hop_now_reg    <= hop_now_next;
            status_reg     <= status_next;
            done_kind_reg  <= done_kind_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tx_request     = tx_request_reg;
    assign tx_packet_type = tx_type_reg;
    assign hop_now        = hop_now_reg;
    assign hop_position   = hop_index_reg;
    assign status         = status_reg;
    assign done_kind      = done_kind_reg;
    assign busy_res       = (phase_reg != PH_IDLE);

    // a finished transaction leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_NONE)) |-> !busy_res)
        else $error("finished transaction still busy");

    // a transmit request only comes from a live transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_request) |-> (busy_res && (tx_packet_type != TYPE_NONE)))
        else $error("tx request without a transaction");

    // success only arrives on a packet, which always hops
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_SUCCESS)) |-> hop_now)
        else $error("success without a hop");

    // a held result is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(hop_position)))
        else $error("stalled result changed");

    // the input side stalls only with a request waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled without a waiting request");

endmodule

`default_nettype wire

[tb/request_reply_retry_hop_controller_tb.sv]
// self-checking testbench for the request/reply retry hop controller
`default_nettype none

module request_reply_retry_hop_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rrhop_pkg::*;

    // overall bound on the run, far above the slowest legal run
    localparam int RUN_LIMIT_NS = 2_000_000;
    // stop generating random phases once this many requests are queued
    localparam int ITEM_TARGET = 1650;
    // cycles the receiver refuses results during the forced hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    // keep a single retry/fail sequence from eating the whole budget
    localparam int MAX_SEQ_COST = 600;
    // index past the last register, writes there are dropped by the block
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    // link phases of the predictor
    typedef enum logic [1:0] {
        LINK_IDLE   = 2'd0,
        LINK_TX     = 2'd1,
        LINK_LISTEN = 2'd2
    } link_phase_t;

    // one request on the input channel
    typedef struct packed {
        cmd_t       code;
        logic       ok;
        logic [4:0] ptype;
    } hop_event_t;

    // one result on the output channel
    typedef struct packed {
        logic       tx_request;
        logic [4:0] tx_packet_type;
        logic       hop_now;
        logic [3:0] hop_position;
        status_t    status;
        logic       done_kind;
        logic       busy_res;
    } hop_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] cmd = 3'd0;
    logic       rx_valid = 1'b0;
    logic [4:0] rx_type = 5'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       tx_request;
    logic [4:0] tx_packet_type;
    logic       hop_now;
    logic [3:0] hop_position;
    status_t    status;
    logic       done_kind;
    logic       busy_res;

    request_reply_retry_hop_controller uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .rx_valid       (rx_valid),
        .rx_type        (rx_type),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .tx_request     (tx_request),
        .tx_packet_type (tx_packet_type),
        .hop_now        (hop_now),
        .hop_position   (hop_position),
        .status         (status),
        .done_kind      (done_kind),
        .busy_res       (busy_res)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // requests waiting for the driver, outcomes waiting for the monitor
    hop_event_t  pending_events[$];
    hop_result_t predicted_outcomes[$];
    int          items_queued = 0;
    int          mismatch_count = 0;
    int          results_seen = 0;

    // idling controls, set between phases by the stimulus process
    bit sender_gaps_on = 1'b1;
    bit receiver_stalls_on = 1'b1;
    bit hold_off_arm = 1'b0;
    logic hold_off = 1'b0;

    // predictor copy of the configuration registers
    logic [4:0] cfg_hops = HOP_COUNT_RESET;
    logic [7:0] cfg_timeout = LISTEN_TIMEOUT_RESET;
    logic [7:0] cfg_retry_limit = MAX_RETRIES_RESET;

    // predictor copy of the link state
    link_phase_t link_phase = LINK_IDLE;
    logic        link_write = 1'b0;
    logic [7:0]  link_timer = 8'd0;
    logic [7:0]  link_retries = 8'd0;
    logic [3:0]  link_hop = 4'd0;

    // gap lengths: mostly short, now and then long
    function automatic int gap_length();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // next hop position; wrap point capped by the channel limit and the 4-bit index
    function automatic void step_hop();
        int wrap;
        int nxt;
        wrap = int'(cfg_hops);
        if (wrap > MAX_HOP_CHANNELS)
        begin
            wrap = MAX_HOP_CHANNELS;
        end
        if (wrap > 16)
        begin
            wrap = 16;
        end
        nxt = int'(link_hop) + 1;
        // a hop count of zero pins the position at zero
        if (nxt >= wrap)
        begin
            nxt = 0;
        end
        link_hop = 4'(nxt);
    endfunction

    // apply one request to the predicted link state and return its outcome
    function automatic hop_result_t apply_event(cmd_t code, logic ok, logic [4:0] ptype);
        hop_result_t res;
        logic [4:0]  reply;
        res = '0;
        case (code)
            CMD_TICK:
            begin
                // ticks only matter while listening
                if (link_phase == LINK_LISTEN)
                begin
                    if (int'(link_timer) + 1 > int'(cfg_timeout))
                    begin
                        link_timer = 8'd0;
                        if (int'(link_retries) + 1 > int'(cfg_retry_limit))
                        begin
                            // retries used up: fail, hop, back to idle
                            link_retries = 8'd0;
                            res.status = STATUS_FAIL;
                            res.done_kind = link_write;
                            link_phase = LINK_IDLE;
                            step_hop();
                            res.hop_now = 1'b1;
                        end
                        else
                        begin
                            link_retries = link_retries + 8'd1;
                            link_phase = LINK_TX;
                            res.tx_request = 1'b1;
                        end
                    end
                    else
                    begin
                        link_timer = link_timer + 8'd1;
                    end
                end
            end
            CMD_START_READ, CMD_START_WRITE:
            begin
                // a start while busy is dropped
                if (link_phase == LINK_IDLE)
                begin
                    link_write = (code == CMD_START_WRITE);
                    link_phase = LINK_TX;
                    link_retries = 8'd0;
                    link_timer = 8'd0;
                    res.tx_request = 1'b1;
                end
            end
            CMD_TX_DONE:
            begin
                if (link_phase == LINK_TX)
                begin
                    step_hop();
                    res.hop_now = 1'b1;
                    link_phase = LINK_LISTEN;
                    link_timer = 8'd0;
                end
            end
            CMD_PKT_RX:
            begin
                // any packet while listening hops, only the matching reply ends it
                if (link_phase == LINK_LISTEN)
                begin
                    reply = link_write ? TYPE_SET_ACK : TYPE_READ_REPLY;
                    step_hop();
                    res.hop_now = 1'b1;
                    if (ok && ptype == reply)
                    begin
                        res.status = STATUS_SUCCESS;
                        res.done_kind = link_write;
                        link_phase = LINK_IDLE;
                        link_retries = 8'd0;
                        link_timer = 8'd0;
                    end
                end
            end
            CMD_EXT_HOP:
            begin
                step_hop();
                res.hop_now = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (res.tx_request)
        begin
            res.tx_packet_type = link_write ? TYPE_SET_REQ : TYPE_READ_REQ;
        end
        res.hop_position = link_hop;
        res.busy_res = (link_phase != LINK_IDLE);
        return res;
    endfunction

    // driver: presents queued requests, predicts each one as it is taken
    hop_event_t next_event;
    int         send_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_TICK;
            rx_valid <= 1'b0;
            rx_type <= 5'd0;
            send_gap = 0;
        end
        else
        begin
            // request taken on this edge
            if (in_valid && !in_stall)
            begin
                predicted_outcomes.push_back(apply_event(cmd_t'(cmd), rx_valid, rx_type));
            end
            // payload only moves when the channel is free
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    next_event = pending_events.pop_front();
                    in_valid <= 1'b1;
                    cmd <= next_event.code;
                    rx_valid <= next_event.ok;
                    rx_type <= next_event.ptype;
                    send_gap = (sender_gaps_on && $urandom_range(0, 99) < 30) ?
                               gap_length() : 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result against the oldest prediction, drives stall
    hop_result_t oldest_outcome;
    int          stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (predicted_outcomes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result %0d: no outcome was predicted", results_seen);
                    end
                end
                else
                begin
                    oldest_outcome = predicted_outcomes.pop_front();
                    if (tx_request !== oldest_outcome.tx_request ||
                        tx_packet_type !== oldest_outcome.tx_packet_type ||
                        hop_now !== oldest_outcome.hop_now ||
                        hop_position !== oldest_outcome.hop_position ||
                        status !== oldest_outcome.status ||
                        done_kind !== oldest_outcome.done_kind ||
                        busy_res !== oldest_outcome.busy_res)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("result %0d: expected tx=%0d type=%0d hop=%0d pos=%0d",
                                     results_seen, oldest_outcome.tx_request,
                                     oldest_outcome.tx_packet_type, oldest_outcome.hop_now,
                                     oldest_outcome.hop_position);
                            $display("    status=%0d kind=%0d busy=%0d", oldest_outcome.status,
                                     oldest_outcome.done_kind, oldest_outcome.busy_res);
                            $display("  got tx=%0d type=%0d hop=%0d pos=%0d", tx_request,
                                     tx_packet_type, hop_now, hop_position);
                            $display("    status=%0d kind=%0d busy=%0d", status, done_kind,
                                     busy_res);
                        end
                    end
                end
            end
            // forced hold-off wins over the random stall pattern
            if (hold_off)
            begin
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (receiver_stalls_on && $urandom_range(0, 99) < 20)
            begin
                stall_left = gap_length() - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here so the sender keeps offering requests
    initial
    begin
        wait (hold_off_arm);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic push_event(input cmd_t code, input logic ok, input logic [4:0] ptype);
        hop_event_t ev;
        ev.code = code;
        ev.ok = ok;
        ev.ptype = ptype;
        pending_events.push_back(ev);
        items_queued++;
    endtask

    // request with random packet fields
    task automatic push_cmd(input cmd_t code);
        push_event(code, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
    endtask

    // anything at all, unused codes included
    task automatic push_noise();
        push_event(cmd_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                   5'($urandom_range(0, 31)));
    endtask

    // external hop or a packet that must not close the transaction
    task automatic push_stray(input logic [4:0] reply);
        logic       ok;
        logic [4:0] ptype;
        ok = 1'($urandom_range(0, 1));
        ptype = 5'($urandom_range(0, 31));
        if (ok && ptype == reply)
        begin
            ok = 1'b0;
        end
        if ($urandom_range(0, 2) == 0)
        begin
            push_event(CMD_EXT_HOP, ok, ptype);
        end
        else
        begin
            push_event(CMD_PKT_RX, ok, ptype);
        end
    endtask

    // one well-formed transaction: start, some timed-out listens, then reply or failure
    task automatic add_transaction(input bit want_fail);
        logic       wr;
        logic [4:0] reply;
        int         rounds;
        int         round_cost;
        int         quiet_ticks;
        bit         fail_run;
        wr = 1'($urandom_range(0, 1));
        reply = wr ? TYPE_SET_ACK : TYPE_READ_REPLY;
        round_cost = int'(cfg_timeout) + 2;
        push_cmd(wr ? CMD_START_WRITE : CMD_START_READ);
        if ($urandom_range(0, 4) == 0)
        begin
            push_noise();
        end
        fail_run = want_fail && (int'(cfg_retry_limit) + 1) * round_cost <= MAX_SEQ_COST;
        if (fail_run)
        begin
            rounds = int'(cfg_retry_limit) + 1;
        end
        else
        begin
            rounds = $urandom_range(0, 2);
            if (rounds > int'(cfg_retry_limit))
            begin
                rounds = int'(cfg_retry_limit);
            end
            if (rounds * round_cost > MAX_SEQ_COST / 2)
            begin
                rounds = (MAX_SEQ_COST / 2) / round_cost;
            end
        end
        // each listen runs one tick past the timeout
        for (int r = 0; r < rounds; r++)
        begin
            push_cmd(CMD_TX_DONE);
            for (int k = 0; k <= int'(cfg_timeout); k++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    push_stray(reply);
                end
                push_cmd(CMD_TICK);
            end
        end
        if (!fail_run)
        begin
            push_cmd(CMD_TX_DONE);
            quiet_ticks = $urandom_range(0, (cfg_timeout < 8'd4) ? int'(cfg_timeout) : 4);
            repeat (quiet_ticks) push_cmd(CMD_TICK);
            if ($urandom_range(0, 2) == 0)
            begin
                push_stray(reply);
            end
            // now and then the reply never comes and the next start is dropped
            if ($urandom_range(0, 9) != 0)
            begin
                push_event(CMD_PKT_RX, 1'b1, reply);
            end
        end
    endtask

    // sender pause: every request taken and every result back
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_events.size() != 0 || in_valid || predicted_outcomes.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_HOP_COUNT:      cfg_hops = data[4:0];
            CFG_LISTEN_TIMEOUT: cfg_timeout = data;
            CFG_MAX_RETRIES:    cfg_retry_limit = data;
            default:            ;
        endcase
    endtask

    // only called with nothing in flight
    task automatic set_config(input logic [7:0] hops, input logic [7:0] tmo,
                              input logic [7:0] lim);
        repeat (4) @(posedge clk);
        write_reg(CFG_HOP_COUNT, hops);
        write_reg(CFG_LISTEN_TIMEOUT, tmo);
        write_reg(CFG_MAX_RETRIES, lim);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // one phase: new settings, then transactions mixed with noise
    task automatic run_phase(input logic [7:0] hops, input logic [7:0] tmo,
                             input logic [7:0] lim, input int budget, input bit force_fail);
        int start_count;
        set_config(hops, tmo, lim);
        start_count = items_queued;
        if (force_fail)
        begin
            add_transaction(1'b1);
        end
        while (items_queued - start_count < budget)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                push_noise();
            end
            else
            begin
                add_transaction($urandom_range(0, 3) == 0);
            end
        end
        wait_drained();
    endtask

    // extreme settings visited before the random ones
    localparam int N_EXTREME = 6;
    localparam logic [7:0] EXT_HOPS[N_EXTREME] = '{8'd16, 8'd1, 8'hFF, 8'd17, 8'd5, 8'd0};
    localparam logic [7:0] EXT_TMO[N_EXTREME]  = '{8'd3, 8'd0, 8'd1, 8'd0, 8'd255, 8'd255};
    localparam logic [7:0] EXT_LIM[N_EXTREME]  = '{8'd2, 8'd0, 8'd3, 8'd255, 8'd1, 8'd255};

    initial
    begin : stimulus
        logic [7:0] hops;
        logic [7:0] tmo;
        logic [7:0] lim;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: ignored events, a read and a write that succeed
        push_event(CMD_TICK, 1'b0, 5'd0);
        push_event(CMD_TX_DONE, 1'b1, 5'd31);
        push_event(CMD_PKT_RX, 1'b1, TYPE_READ_REPLY);
        push_event(CMD_EXT_HOP, 1'b0, 5'd0);
        push_event(CMD_RSVD6, 1'b1, 5'd31);
        push_event(CMD_RSVD7, 1'b0, 5'd0);
        push_event(CMD_START_READ, 1'b0, 5'd0);
        push_event(CMD_START_WRITE, 1'b1, 5'd31);
        push_event(CMD_PKT_RX, 1'b1, TYPE_READ_REPLY);
        push_event(CMD_TICK, 1'b1, 5'd31);
        push_event(CMD_TX_DONE, 1'b0, 5'd0);
        push_event(CMD_PKT_RX, 1'b0, TYPE_READ_REPLY);
        push_event(CMD_PKT_RX, 1'b1, TYPE_SET_ACK);
        push_event(CMD_TICK, 1'b0, 5'd0);
        push_event(CMD_PKT_RX, 1'b1, TYPE_READ_REPLY);
        push_event(CMD_START_WRITE, 1'b0, 5'd0);
        push_event(CMD_TX_DONE, 1'b0, 5'd0);
        push_event(CMD_PKT_RX, 1'b1, TYPE_READ_REPLY);
        push_event(CMD_EXT_HOP, 1'b1, 5'd31);
        push_event(CMD_PKT_RX, 1'b1, TYPE_SET_ACK);
        wait_drained();

        // zero hop count, zero timeout, one retry: retry then failure of a write
        set_config(8'd0, 8'd0, 8'd1);
        push_event(CMD_START_WRITE, 1'b0, 5'd0);
        push_event(CMD_TX_DONE, 1'b0, 5'd0);
        push_event(CMD_TICK, 1'b0, 5'd0);
        push_event(CMD_TX_DONE, 1'b0, 5'd0);
        push_event(CMD_TICK, 1'b0, 5'd0);
        push_event(CMD_EXT_HOP, 1'b0, 5'd0);
        wait_drained();

        // unused register index, must leave the settings alone
        write_reg(CFG_UNUSED_INDEX, 8'hA5);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);

        for (int p = 0; p < N_EXTREME; p++)
        begin
            // first phase: long receiver hold-off so the block backs up
            if (p == 0)
            begin
                hold_off_arm = 1'b1;
            end
            sender_gaps_on = (p % 3 != 2);
            receiver_stalls_on = (p % 3 != 2);
            run_phase(EXT_HOPS[p], EXT_TMO[p], EXT_LIM[p], 100, 1'b1);
        end

        // random settings, mostly small so retries and failures stay frequent
        while (items_queued < ITEM_TARGET)
        begin
            hops = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(1, 16)) :
                   8'($urandom_range(0, 255));
            tmo = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 10)) :
                  8'($urandom_range(0, 255));
            lim = ($urandom_range(0, 99) < 60) ? 8'($urandom_range(0, 5)) :
                  8'($urandom_range(0, 255));
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            receiver_stalls_on = ($urandom_range(0, 3) != 0);
            run_phase(hops, tmo, lim, 150, 1'b0);
        end

        // let any stray result show up
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && predicted_outcomes.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
